/* hw/rtl/pcbr_pkg.sv */
// Shared types and constants of the per-core bandwidth regulator.
`timescale 1ns / 1ps
`default_nettype none

package pcbr_pkg;

  localparam int unsigned CoreW    = 2;
  localparam int unsigned CountW   = 8;
  localparam int unsigned UsedW    = 32;
  localparam int unsigned BudgetW  = 24;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned NumBudgetRegs = 4;

  localparam logic [BudgetW-1:0] BUDGET_RESET = BudgetW'(4096);
  localparam logic [PeriodW-1:0] PERIOD_RESET = PeriodW'(1000);
  localparam logic [UsedW-1:0]   USED_MAX     = {UsedW{1'b1}};

  // Request kinds carried in tuser.
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BUDGET0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BUDGET1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BUDGET2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BUDGET3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MASTER  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PERIOD  = 3'd5;

  // Period timer status seen by the update stage.
  typedef struct packed {
    logic               wrap;    // this tick closes the period
    logic [PeriodW-1:0] number;  // period count after this request
  } period_status_t;

endpackage : pcbr_pkg

`default_nettype wire

/* hw/rtl/pcbr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pcbr_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : pcbr_ram

`default_nettype wire

/* hw/rtl/pcbr_period.sv */
// Period timer: tick counter and completed-period count.
`timescale 1ns / 1ps
`default_nettype none

module pcbr_period
  import pcbr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               tick_i,   // pending request is a tick
  input  wire logic               adv_i,    // pending request commits
  input  wire logic [PeriodW-1:0] period_ticks_i,
  output period_status_t          status_o
);

  logic [PeriodW-1:0] tick_q, tick_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic [PeriodW-1:0] limit;
  logic [PeriodW-1:0] tick_inc;

  always_comb begin
    limit    = (period_ticks_i == '0) ? PeriodW'(1) : period_ticks_i;
    tick_inc = tick_q + PeriodW'(1);
    status_o.wrap   = tick_i && (tick_inc >= limit);
    status_o.number = status_o.wrap ? count_q + PeriodW'(1) : count_q;
    tick_d  = tick_q;
    count_d = count_q;
    if (adv_i && tick_i) begin
      tick_d  = status_o.wrap ? '0 : tick_inc;
      count_d = status_o.number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      count_q <= '0;
    end else begin
      tick_q  <= tick_d;
      count_q <= count_d;
    end
  end

endmodule : pcbr_period

`default_nettype wire

/* hw/rtl/per_core_bandwidth_regulator.sv */
// Top level of the per-core memory bandwidth regulator.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Slave stream: one request per handshake. tuser selects a miss-event
//   report (0) or a time tick (1); tdata carries the core index and the
//   event count. Master stream: one result per request, carrying the
//   throttle mask, the one-time overflow flag, the new-period flag, the
//   period number and the reporting core's event count this period.
//   The RAM read is registered together with the request at the accepting
//   edge, and the read-modify-write then loads the output register.
//   Throughput: one request per cycle while the receiver takes results;
//   the rate is set by the single per-core counter RAM, with same-core
//   back-to-back updates forwarded from the last write.
//   Reset clears the pipeline, all per-core counters (by per-core valid
//   bits), the throttle flags, the tick counter and the period count, and
//   loads the budget registers with 4096. No clearing pass is needed.
//   When the receiver stalls, the result holds in the output register and
//   the update stage holds its request; tready drops until it drains.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the block is idle.
module per_core_bandwidth_regulator
  import pcbr_pkg::*;
#(
  parameter int unsigned NUM_CORES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [1:0] core, [9:2] event_count
  input  wire logic                s_axis_tuser,  // [0] func
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [3:0] thr_mask, [4] overflow, [5] period_start,
  // [37:6] period_number, [69:38] used_events
  output logic [OutDataW-1:0]      m_axis_tdata,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned EntryW = UsedW + 1;  // overflow mark above the counter

  // ---------------------------------------------------------------- config
  logic [BudgetW-1:0] budget_q [NumBudgetRegs];
  logic [CoreW-1:0]   master_q;
  logic [PeriodW-1:0] period_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBudgetRegs; i++) begin
        budget_q[i] <= BUDGET_RESET;
      end
      master_q       <= '0;
      period_ticks_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BUDGET0: budget_q[0]    <= cfg_wdata_i[BudgetW-1:0];
        REG_BUDGET1: budget_q[1]    <= cfg_wdata_i[BudgetW-1:0];
        REG_BUDGET2: budget_q[2]    <= cfg_wdata_i[BudgetW-1:0];
        REG_BUDGET3: budget_q[3]    <= cfg_wdata_i[BudgetW-1:0];
        REG_MASTER:  master_q       <= cfg_wdata_i[CoreW-1:0];
        REG_PERIOD:  period_ticks_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------ handshakes
  logic s1_vld_q;
  logic s1_func_q;
  logic [CoreW-1:0]  s1_core_q;
  logic [CountW-1:0] s1_cnt_q;
  logic s1_adv;
  logic in_acc;

  // The update stage advances whenever the output register is free or drains.
  assign s1_adv        = s1_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= s_axis_tuser;
      s1_core_q <= s_axis_tdata[CoreW-1:0];
      s1_cnt_q  <= s_axis_tdata[CoreW +: CountW];
    end
  end

  // ------------------------------------------------------- per-core RAM
  logic              ram_we;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  // Read on accept only, so the read data holds while the stage stalls.
  pcbr_ram #(
    .WIDTH (EntryW),
    .DEPTH (NUM_CORES)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(s1_core_q)),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (AW'(s_axis_tdata[CoreW-1:0])),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------- period timer
  period_status_t per_status;

  pcbr_period u_period (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (s1_vld_q && (s1_func_q == FUNC_TICK)),
    .adv_i          (s1_adv),
    .period_ticks_i (period_ticks_q),
    .status_o       (per_status)
  );

  // --------------------------------------------------------- update stage
  logic [NUM_CORES-1:0] vld_q, vld_d;       // entry written this period
  logic [MaskW-1:0]     thr_q, thr_d;       // throttle flags, cores 0..3
  logic [BudgetW-1:0]   eff_q [NumBudgetRegs];
  logic                 wr_vld_q;           // last RAM write, for forwarding
  logic [CoreW-1:0]     wr_core_q;
  logic [EntryW-1:0]    wr_data_q;

  logic              is_event;
  logic              in_range;
  logic [EntryW-1:0] cur;
  logic [UsedW:0]    sum;
  logic [UsedW-1:0]  used_new;
  logic              hit;
  logic              ev_ovf;
  logic              is_master;
  logic [UsedW-1:0]  used_out;

  always_comb begin
    is_event  = (s1_func_q == FUNC_EVENT);
    in_range  = 32'(s1_core_q) < NUM_CORES;
    is_master = (s1_core_q == master_q);
    // Newest value of the entry: last write, RAM data, or cleared.
    if (wr_vld_q && (wr_core_q == s1_core_q)) begin
      cur = wr_data_q;
    end else if (in_range && vld_q[AW'(s1_core_q)]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
    sum      = {1'b0, cur[UsedW-1:0]} + (UsedW + 1)'(s1_cnt_q);
    used_new = sum[UsedW] ? USED_MAX : sum[UsedW-1:0];
    hit      = !cur[UsedW] && (used_new >= UsedW'(eff_q[s1_core_q]));
    ev_ovf   = is_event && in_range && hit;
    used_out = (is_event && in_range) ? used_new : '0;
    ram_we    = s1_adv && is_event && in_range;
    ram_wdata = {cur[UsedW] | hit, used_new};

    vld_d = vld_q;
    thr_d = thr_q;
    if (per_status.wrap) begin
      vld_d = '0;
      thr_d = '0;
    end else if (is_event && in_range) begin
      vld_d[AW'(s1_core_q)] = 1'b1;
      if (ev_ovf && !is_master) begin
        thr_d[s1_core_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      thr_q    <= '0;
      wr_vld_q <= 1'b0;
      for (int i = 0; i < NumBudgetRegs; i++) begin
        eff_q[i] <= BUDGET_RESET;
      end
    end else if (s1_adv) begin
      vld_q <= vld_d;
      thr_q <= thr_d;
      if (per_status.wrap) begin
        wr_vld_q <= 1'b0;
        // Reload each budget whose register is nonzero.
        for (int i = 0; i < NumBudgetRegs; i++) begin
          if (budget_q[i] != '0) begin
            eff_q[i] <= budget_q[i];
          end
        end
      end else if (ram_we) begin
        wr_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wr_core_q <= s1_core_q;
      wr_data_q <= ram_wdata;
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_axis_tdata <= {2'b00, used_out, per_status.number, per_status.wrap,
                       ev_ovf, thr_d};
    end
  end

  // ----------------------------------------------------------- assertions
  a_throttle_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && ev_ovf && !is_master |=> thr_q[$past(s1_core_q)])
    else $error("overflowing core not throttled");

  a_period_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && per_status.wrap |=> (thr_q == '0) && (vld_q == '0) && !wr_vld_q)
    else $error("period start left per-core state set");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request stalled with an empty output register");

  a_tick_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !is_event |=> (m_axis_tdata[4] == 1'b0) && (m_axis_tdata[69:38] == '0))
    else $error("tick result carries event data");

endmodule : per_core_bandwidth_regulator

`default_nettype wire

/* bench/per_core_bandwidth_regulator_tb.sv */
// Self-checking bench for the per-core bandwidth regulator: directed table, then random phases.
`timescale 1ns / 1ps

module per_core_bandwidth_regulator_tb
  import pcbr_pkg::*;
();

  localparam int unsigned NCORES     = 4;
  localparam int unsigned MAX_CYCLES = 200000;
  // Results pass the update stage, then the output register; keep this margin before touching the registers.
  localparam int unsigned SETTLE     = 6;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_REQS = 96;
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd6;

  // Result fields, declared MSB first so the struct matches the tdata layout.
  typedef struct packed {
    logic [UsedW-1:0]   used_events;
    logic [PeriodW-1:0] period_number;
    logic               period_start;
    logic               overflow;
    logic [MaskW-1:0]   thr_mask;
  } rate_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of the directed plan: either a request (repeated reps times,
  // the last one checked against a typed value when typed is set) or a
  // register write.
  typedef struct {
    row_kind_e            kind;
    logic                 func;
    logic [CoreW-1:0]     core;
    logic [CountW-1:0]    cnt;
    int unsigned          reps;
    bit                   typed;
    rate_result_t         want;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
  } plan_row_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // DUT connections; the inputs driven here are known from time zero.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [1:0] core, [9:2] event_count
  logic                s_axis_tuser = 1'b0; // [0] func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  // [3:0] thr_mask, [4] overflow, [5] period_start,
  // [37:6] period_number, [69:38] used_events
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Register copies as the regulator sees them.
  logic [BudgetW-1:0]  budget_reg [NCORES];
  logic [CoreW-1:0]    master_reg;
  logic [PeriodW-1:0]  period_reg;

  // Regulator state mirror.
  logic [UsedW-1:0]    used_cnt   [NCORES];
  logic [BudgetW-1:0]  eff_budget [NCORES];
  logic                throttled  [NCORES];
  logic                ovf_seen   [NCORES];
  logic [PeriodW-1:0]  tick_cnt;
  logic [PeriodW-1:0]  period_tally;

  rate_result_t        pending_results [$];
  plan_row_t           plan_rows [$];
  int unsigned         mismatches = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         burst_left = 0;
  rx_mode_e            rx_mode = RX_FREE;
  int unsigned         rx_left = 0;

  per_core_bandwidth_regulator #(
    .NUM_CORES(NCORES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the regulator mirror by one accepted request and return the
  // result it must produce.
  function automatic rate_result_t regulate_request(logic func, logic [CoreW-1:0] core,
                                                    logic [CountW-1:0] cnt);
    rate_result_t      res;
    logic [PeriodW-1:0] lim;
    logic [UsedW:0]    sum;
    int                k;
    res = '0;
    if (func == FUNC_TICK) begin
      // A zero period behaves as a period of one tick.
      lim = (period_reg == '0) ? PeriodW'(1) : period_reg;
      tick_cnt = tick_cnt + PeriodW'(1);
      if (tick_cnt >= lim) begin
        // Open a new period: clear everything, reload nonzero budgets.
        tick_cnt = '0;
        period_tally = period_tally + PeriodW'(1);
        for (k = 0; k < NCORES; k++) begin
          used_cnt[k]  = '0;
          throttled[k] = 1'b0;
          ovf_seen[k]  = 1'b0;
          if (budget_reg[k] != '0) eff_budget[k] = budget_reg[k];
        end
        res.period_start = 1'b1;
      end
    end else begin
      // Saturate the per-core count at all ones.
      sum = {1'b0, used_cnt[core]} + (UsedW + 1)'(cnt);
      used_cnt[core] = sum[UsedW] ? USED_MAX : sum[UsedW-1:0];
      if (!ovf_seen[core] && used_cnt[core] >= eff_budget[core]) begin
        ovf_seen[core] = 1'b1;
        res.overflow = 1'b1;
        // The master core gets its overflow but is never throttled.
        if (core != master_reg) throttled[core] = 1'b1;
      end
      res.used_events = used_cnt[core];
    end
    for (k = 0; k < MaskW; k++) res.thr_mask[k] = throttled[k];
    res.period_number = period_tally;
    return res;
  endfunction

  // Plan builders for the directed table.
  function automatic void queue_request(logic func, logic [CoreW-1:0] core,
                                        logic [CountW-1:0] cnt, int unsigned reps);
    plan_row_t row;
    row = '{kind: ROW_REQ, func: func, core: core, cnt: cnt, reps: reps,
            typed: 1'b0, want: '0, idx: '0, data: '0};
    plan_rows.push_back(row);
  endfunction

  function automatic void queue_checked(logic func, logic [CoreW-1:0] core,
                                        logic [CountW-1:0] cnt, logic [MaskW-1:0] mask,
                                        logic ovf, logic newp, logic [PeriodW-1:0] per,
                                        logic [UsedW-1:0] used);
    plan_row_t row;
    row = '{kind: ROW_REQ, func: func, core: core, cnt: cnt, reps: 1, typed: 1'b1,
            want: '{used_events: used, period_number: per, period_start: newp,
                    overflow: ovf, thr_mask: mask},
            idx: '0, data: '0};
    plan_rows.push_back(row);
  endfunction

  function automatic void queue_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, func: 1'b0, core: '0, cnt: '0, reps: 0, typed: 1'b0,
            want: '0, idx: idx, data: data};
    plan_rows.push_back(row);
  endfunction

  // Present one request and hold it until it is taken. Bursts of random
  // length are separated by random gaps with tvalid low.
  task automatic send_request(logic func, logic [CoreW-1:0] core, logic [CountW-1:0] cnt,
                              bit typed, rate_result_t want);
    rate_result_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= InDataW'({cnt, core});
    do @(posedge clk_i); while (!s_axis_tready);
    // Accepted at this edge: advance the mirror and record what must come out.
    pred = regulate_request(func, core, cnt);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Drop tvalid, let every pending result drain, then let the pipe settle.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Drive one register write and mirror it; the caller lowers the enable.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_BUDGET0, REG_BUDGET1, REG_BUDGET2, REG_BUDGET3:
        budget_reg[idx[1:0]] = data[BudgetW-1:0];
      REG_MASTER: master_reg = data[CoreW-1:0];
      REG_PERIOD: period_reg = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver: pick a stall mode for a stretch of cycles, then move on.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= (rx_left % 5 != 0);
    endcase
  end

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    rate_result_t got;
    rate_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rate_result_t'(m_axis_tdata[$bits(rate_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.thr_mask !== want.thr_mask) begin
          $error("thr_mask: expected %h, got %h", want.thr_mask, got.thr_mask);
          mismatches++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
          mismatches++;
        end
        if (got.period_start !== want.period_start) begin
          $error("period_start: expected %0d, got %0d", want.period_start,
                 got.period_start);
          mismatches++;
        end
        if (got.period_number !== want.period_number) begin
          $error("period_number: expected %0d, got %0d", want.period_number,
                 got.period_number);
          mismatches++;
        end
        if (got.used_events !== want.used_events) begin
          $error("used_events: expected %0d, got %0d", want.used_events, got.used_events);
          mismatches++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int                  i;
    int unsigned         n;
    int unsigned         ph;
    int                  k;
    logic [CfgDataW-1:0] data;
    logic [BudgetW-1:0]  bval;
    logic                func;
    logic [CountW-1:0]   cnt;

    // Mirror starts from the reset state.
    for (k = 0; k < NCORES; k++) begin
      budget_reg[k] = BUDGET_RESET;
      eff_budget[k] = BUDGET_RESET;
      used_cnt[k]   = '0;
      throttled[k]  = 1'b0;
      ovf_seen[k]   = 1'b0;
    end
    master_reg   = '0;
    period_reg   = PERIOD_RESET;
    tick_cnt     = '0;
    period_tally = '0;

    // Directed plan, starting from reset values: master 0, period 1000,
    // budgets 4096.
    queue_checked(FUNC_EVENT, 2'd0, 8'd0,   4'b0000, 1'b0, 1'b0, 0, 0);
    // Tick ignores core and count.
    queue_checked(FUNC_TICK,  2'd3, 8'd255, 4'b0000, 1'b0, 1'b0, 0, 0);
    // Climb core 1 to the reset budget: 16 x 255 is 4080, one more crosses.
    queue_request(FUNC_EVENT, 2'd1, 8'd255, 15);
    queue_checked(FUNC_EVENT, 2'd1, 8'd255, 4'b0000, 1'b0, 1'b0, 0, 4080);
    queue_checked(FUNC_EVENT, 2'd1, 8'd255, 4'b0010, 1'b1, 1'b0, 0, 4335);
    // Overflow fires once per period.
    queue_checked(FUNC_EVENT, 2'd1, 8'd16,  4'b0010, 1'b0, 1'b0, 0, 4351);
    // Zero period: every tick opens a period and clears the counters.
    queue_write(REG_PERIOD, 32'd0);
    queue_checked(FUNC_TICK,  2'd0, 8'd0,   4'b0000, 1'b0, 1'b1, 1, 0);
    queue_checked(FUNC_TICK,  2'd2, 8'd170, 4'b0000, 1'b0, 1'b1, 2, 0);
    queue_checked(FUNC_EVENT, 2'd1, 8'd0,   4'b0000, 1'b0, 1'b0, 2, 0);
    // Extreme budgets, zero budget keeps the old one, master is core 3;
    // upper data bits beyond each register must be dropped.
    queue_write(REG_BUDGET0, 32'hFF00_0001);
    queue_write(REG_BUDGET1, 32'h0000_0000);
    queue_write(REG_BUDGET2, 32'h00FF_FFFF);
    queue_write(REG_BUDGET3, 32'h0000_0001);
    queue_write(REG_MASTER,  32'hFFFF_FFFF);
    queue_write(REG_PERIOD,  32'd1);
    queue_checked(FUNC_TICK,  2'd1, 8'd85,  4'b0000, 1'b0, 1'b1, 3, 0);
    queue_write(REG_PERIOD,  32'hFFFF_FFFF);
    queue_checked(FUNC_EVENT, 2'd0, 8'd1,   4'b0001, 1'b1, 1'b0, 3, 1);
    // Master overflows but stays unthrottled.
    queue_checked(FUNC_EVENT, 2'd3, 8'd255, 4'b0001, 1'b1, 1'b0, 3, 255);
    queue_checked(FUNC_EVENT, 2'd2, 8'd255, 4'b0001, 1'b0, 1'b0, 3, 255);
    queue_request(FUNC_EVENT, 2'd0, 8'd255, 1);
    queue_request(FUNC_TICK,  2'd0, 8'd0,   1);

    // Hold reset from time zero, then release it once.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan. Registers change only once the block is idle.
    for (i = 0; i < plan_rows.size(); i++) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        if (i == 0 || plan_rows[i-1].kind != ROW_CFG) wait_drain();
        write_reg(plan_rows[i].idx, plan_rows[i].data);
        if (i + 1 == plan_rows.size() || plan_rows[i+1].kind != ROW_CFG)
          cfg_we_i <= 1'b0;
      end else begin
        for (n = 0; n < plan_rows[i].reps; n++)
          send_request(plan_rows[i].func, plan_rows[i].core, plan_rows[i].cnt,
                       plan_rows[i].typed && (n + 1 == plan_rows[i].reps),
                       plan_rows[i].want);
      end
    end

    // Random phases: new settings, then a stream of ticks and event reports.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      for (k = 0; k < NumBudgetRegs; k++) begin
        if (ph == 0 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       bval = '0;
            1:       bval = '1;
            default: bval = BudgetW'($urandom_range(1, 1500));
          endcase
          if (ph == 3) bval = '1;
          if (ph == 4) bval = '0;
          data = $urandom();
          data[BudgetW-1:0] = bval;
          write_reg(REG_BUDGET0 + CfgIdxW'(k), data);
        end
      end
      if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_MASTER, $urandom());
      if (ph == 0 || ph == 1 || ph == 2 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       data = '0;
          1:       data = '1;
          default: data = $urandom_range(1, 30);
        endcase
        if (ph == 1) data = '0;
        if (ph == 2) data = '1;
        write_reg(REG_PERIOD, data);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
      cfg_we_i <= 1'b0;

      for (n = 0; n < PHASE_REQS; n++) begin
        func = ($urandom_range(0, 4) == 0) ? FUNC_TICK : FUNC_EVENT;
        case ($urandom_range(0, 7))
          0:       cnt = '0;
          1:       cnt = '1;
          default: cnt = CountW'($urandom_range(0, 255));
        endcase
        send_request(func, CoreW'($urandom_range(0, NCORES - 1)), cnt, 1'b0, '0);
      end
    end

    // Drain everything, give the pipe its latency, then report.
    wait_drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* per_core_bandwidth_regulator.f */
hw/rtl/pcbr_pkg.sv
hw/rtl/pcbr_ram.sv
hw/rtl/pcbr_period.sv
hw/rtl/per_core_bandwidth_regulator.sv
bench/per_core_bandwidth_regulator_tb.sv
